### design/olids_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list package
// Shared constants, operation and status codes, and the control word that is
// sent to each cell of the list.
// ----------------------------------------------------------------------------
`default_nettype none

package olids_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam int MODE_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 16;
    localparam int STATUS_W = 2;
    localparam int FPOS_W   = 4;
    localparam int LEN_W    = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_SEARCH = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_KEEP  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_LEFT  = 2'd2,
        CELL_RIGHT = 2'd3
    } t_cell_cmd;

    typedef struct packed {
        logic      cmp_en;
        logic      in_list;
        t_cell_cmd cmd;
    } t_cell_ctrl;

endpackage

`default_nettype wire

### design/olids_if.sv
// ----------------------------------------------------------------------------
// Ordered list channels
// Valid/ready channels for operation beats in and result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface olids_in_if;
    logic                                      valid;
    logic                                      ready;
    logic [olids_pkg::MODE_W-1:0]              mode;
    logic signed [olids_pkg::VALUE_W-1:0]      value;
    logic [olids_pkg::POS_W-1:0]               position;

    modport source (output valid, output mode, output value, output position, input ready);
    modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface olids_out_if;
    logic                                      valid;
    logic                                      ready;
    logic [olids_pkg::STATUS_W-1:0]            status;
    logic [olids_pkg::FPOS_W-1:0]              found_position;
    logic [olids_pkg::LEN_W-1:0]               length;

    modport source (output valid, output status, output found_position, output length,
                    input ready);
    modport sink   (input valid, input status, input found_position, input length,
                    output ready);
endinterface

`default_nettype wire

### design/olids_cell.sv
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one entry, compares it with the operand and takes its next value from
// the operand or from either neighbour. Passes the match flag along the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module olids_cell (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire olids_pkg::t_cell_ctrl                i_ctrl,
    input  wire logic signed [olids_pkg::VALUE_W-1:0] i_value,
    input  wire logic signed [olids_pkg::VALUE_W-1:0] i_left,
    input  wire logic signed [olids_pkg::VALUE_W-1:0] i_right,
    input  wire logic                                 i_seen,
    output logic signed [olids_pkg::VALUE_W-1:0]      o_data,
    output logic                                      o_seen,
    output logic                                      o_first
);

    logic signed [olids_pkg::VALUE_W-1:0] r_data;
    logic signed [olids_pkg::VALUE_W-1:0] n_data;
    logic                                 r_match;

    always_comb begin
        case (i_ctrl.cmd)
            olids_pkg::CELL_LOAD:  n_data = i_value;
            olids_pkg::CELL_LEFT:  n_data = i_left;
            olids_pkg::CELL_RIGHT: n_data = i_right;
            default:               n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctrl.cmp_en) begin
            r_match <= i_ctrl.in_list && (r_data == i_value);
        end
    end

    assign o_data  = r_data;
    assign o_seen  = i_seen | r_match;
    assign o_first = r_match & ~i_seen;

endmodule

`default_nettype wire

### design/ordered_list_insert_delete_search.sv
// ----------------------------------------------------------------------------
// Ordered list with insert, delete and search
// A row of cells holding up to CAPACITY signed entries in order.
// ----------------------------------------------------------------------------
// Each operation beat is accepted in S_IDLE; in S_CMP every cell compares its
// entry with the operand, and in S_EXEC the first-match flag ripples along the
// cell chain and all cells shift or load at once. The result sits in an
// output register, so the next operation beat is accepted while a result beat
// still waits to be taken. An append or insert on a full list is refused with
// status full; a delete or search that finds nothing reports not found with
// position zero. found_position and length carry the low bits of the internal
// position and count.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_insert_delete_search #(
    parameter int CAPACITY = olids_pkg::CAPACITY_DEFAULT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    olids_in_if.sink   i_in,
    olids_out_if.source o_out
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } t_state;

    t_state                                r_state;
    olids_pkg::t_mode                      r_mode;
    logic signed [olids_pkg::VALUE_W-1:0]  r_value;
    logic [olids_pkg::POS_W-1:0]           r_pos;
    logic [CW-1:0]                         r_count;
    logic                                  r_out_valid;
    olids_pkg::t_status                    r_status;
    logic [olids_pkg::FPOS_W-1:0]          r_fpos;
    logic [olids_pkg::LEN_W-1:0]           r_len;

    olids_pkg::t_cell_ctrl                 cell_ctrl [CAPACITY];
    logic signed [olids_pkg::VALUE_W-1:0]  cell_data [CAPACITY];
    logic [CAPACITY:0]                     seen;
    logic [CAPACITY-1:0]                   first;

    logic          accept;
    logic          finish;
    logic          is_add;
    logic          full;
    logic          hit_any;
    logic          add_ok;
    logic          del_ok;
    logic [CW-1:0] ins_p;
    logic [IW-1:0] first_idx;

    assign accept  = i_in.valid && i_in.ready;
    assign finish  = (r_state == S_EXEC) && (!r_out_valid || o_out.ready);
    assign is_add  = (r_mode == olids_pkg::MODE_APPEND) || (r_mode == olids_pkg::MODE_INSERT);
    assign full    = (r_count == CW'(CAPACITY));
    assign hit_any = seen[CAPACITY];
    assign add_ok  = is_add && !full;
    assign del_ok  = (r_mode == olids_pkg::MODE_DELETE) && hit_any;

    always_comb begin
        if ((r_mode == olids_pkg::MODE_APPEND) || (r_pos >= olids_pkg::POS_W'(r_count))) begin
            ins_p = r_count;
        end else begin
            ins_p = CW'(r_pos);
        end
    end

    always_comb begin
        first_idx = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (first[k]) begin
                first_idx = first_idx | IW'(k);
            end
        end
    end

    assign seen[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [olids_pkg::VALUE_W-1:0] left;
        logic signed [olids_pkg::VALUE_W-1:0] right;

        if (g == 0) begin : g_first
            assign left = r_value;
        end else begin : g_mid
            assign left = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right = cell_data[g];
        end else begin : g_inner
            assign right = cell_data[g+1];
        end

        always_comb begin
            cell_ctrl[g].cmp_en  = (r_state == S_CMP);
            cell_ctrl[g].in_list = (CW'(g) < r_count);
            cell_ctrl[g].cmd     = olids_pkg::CELL_KEEP;
            if (finish) begin
                if (add_ok) begin
                    if (CW'(g) == ins_p) begin
                        cell_ctrl[g].cmd = olids_pkg::CELL_LOAD;
                    end else if (CW'(g) > ins_p) begin
                        cell_ctrl[g].cmd = olids_pkg::CELL_LEFT;
                    end
                end else if (del_ok && seen[g+1]) begin
                    cell_ctrl[g].cmd = olids_pkg::CELL_RIGHT;
                end
            end
        end

        olids_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl[g]),
            .i_value (r_value),
            .i_left  (left),
            .i_right (right),
            .i_seen  (seen[g]),
            .o_data  (cell_data[g]),
            .o_seen  (seen[g+1]),
            .o_first (first[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (finish) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        if (add_ok) begin
                            r_count <= r_count + CW'(1);
                        end else if (del_ok) begin
                            r_count <= r_count - CW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= olids_pkg::t_mode'(i_in.mode);
            r_value <= i_in.value;
            r_pos   <= i_in.position;
        end
        if (finish) begin
            if (is_add) begin
                r_status <= full ? olids_pkg::ST_FULL : olids_pkg::ST_OK;
                r_fpos   <= '0;
                r_len    <= full ? olids_pkg::LEN_W'(r_count)
                                 : olids_pkg::LEN_W'(r_count + CW'(1));
            end else begin
                r_status <= hit_any ? olids_pkg::ST_OK : olids_pkg::ST_NOT_FOUND;
                r_fpos   <= hit_any ? olids_pkg::FPOS_W'(first_idx) : '0;
                r_len    <= del_ok ? olids_pkg::LEN_W'(r_count - CW'(1))
                                   : olids_pkg::LEN_W'(r_count);
            end
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_status;
    assign o_out.found_position = r_fpos;
    assign o_out.length         = r_len;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("Entry count exceeds capacity.");

    a_single_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(first))
        else $error("More than one cell claims the first match.");

    a_accept_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_CMP))
        else $error("Accepted beat did not start a compare cycle.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> ((r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1))
                    || (r_count == $past(r_count) - CW'(1))))
        else $error("Entry count moved by more than one.");

    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && !is_add && !hit_any) |=> (r_status == olids_pkg::ST_NOT_FOUND))
        else $error("Missing value was not reported as not found.");

endmodule

`default_nettype wire
